// ===== sv/dpwpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpwpc_pkg
// Shared types and constants for the dual pulse-width and phase capture block.
// ----------------------------------------------------------------------------
package dpwpc_pkg;

   localparam int COUNT_BITS    = 32;
   localparam int WIDTH_BITS    = 32;
   localparam int PRESCALE_BITS = 16;
   localparam int WRAPS_BITS    = 6;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [WRAPS_BITS-1:0]   WRAPS_MAX     = '1;
   localparam logic [WIDTH_BITS-1:0]   WIDTH_SAT     = '1;
   localparam logic [CSR_DATA_BITS-1:0] RELOAD_RESET = '1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_RELOAD_LIMIT = 1'b0,
      REG_PRESCALE     = 1'b1
   } csr_index_type;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] reload_limit;
      logic [PRESCALE_BITS-1:0] prescale;
   } cfg_type;

   typedef struct packed {
      logic                  done;
      logic                  armed;
      logic [WRAPS_BITS-1:0] wraps;
      logic [WIDTH_BITS-1:0] width;
   } chan_status_type;

endpackage

// ===== sv/dpwpc_if.sv =====
// ----------------------------------------------------------------------------
// dpwpc channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpwpc_req_if;
   logic valid;
   logic ready;
   logic level_a;
   logic level_b;
   logic clear_a;
   logic clear_b;

   modport source (output valid, level_a, level_b, clear_a, clear_b, input ready);
   modport sink   (input valid, level_a, level_b, clear_a, clear_b, output ready);
endinterface

interface dpwpc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             done_a;
   logic                             armed_a;
   logic [dpwpc_pkg::WRAPS_BITS-1:0] wraps_a;
   logic [dpwpc_pkg::WIDTH_BITS-1:0] width_a;
   logic                             done_b;
   logic                             armed_b;
   logic [dpwpc_pkg::WRAPS_BITS-1:0] wraps_b;
   logic [dpwpc_pkg::WIDTH_BITS-1:0] width_b;
   logic [dpwpc_pkg::WIDTH_BITS-1:0] phase_count;

   modport source (output valid, done_a, armed_a, wraps_a, width_a,
                   done_b, armed_b, wraps_b, width_b, phase_count, input ready);
   modport sink   (input valid, done_a, armed_a, wraps_a, width_a,
                   done_b, armed_b, wraps_b, width_b, phase_count, output ready);
endinterface

interface dpwpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dpwpc_pkg::CSR_IDX_BITS-1:0]  index;
   logic [dpwpc_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dpwpc_channel.sv =====
// ----------------------------------------------------------------------------
// dpwpc_channel
// One capture channel: prescaler, wrapping counter, edge detect and status.
// ----------------------------------------------------------------------------
module dpwpc_channel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        level,
   input  logic                        clear,
   input  dpwpc_pkg::cfg_type          cfg,
   output dpwpc_pkg::chan_status_type  status_next,
   output dpwpc_pkg::count_type        count_next,
   output logic                        armed_rise
);

   logic [dpwpc_pkg::PRESCALE_BITS-1:0] pre_ff, pre_in;
   dpwpc_pkg::count_type                cnt_ff, cnt_in, cnt_adv, lim;
   logic                                last_ff;
   dpwpc_pkg::chan_status_type          status_ff, st;
   logic                                wrap, rise, fall;

   assign lim  = cfg.reload_limit[dpwpc_pkg::COUNT_BITS-1:0];
   assign rise = level & ~last_ff;
   assign fall = ~level & last_ff;

   always_comb begin
      pre_in  = pre_ff + 1'b1;
      cnt_adv = cnt_ff;
      wrap    = 1'b0;
      if (pre_ff >= cfg.prescale) begin
         pre_in = '0;
         if (cnt_ff >= lim) begin
            cnt_adv = '0;
            wrap    = 1'b1;
         end else begin
            cnt_adv = cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      st         = status_ff;
      cnt_in     = cnt_adv;
      armed_rise = 1'b0;
      if (clear) begin
         st.done  = 1'b0;
         st.armed = 1'b0;
         st.wraps = '0;
      end
      if (!st.done) begin
         if (wrap && st.armed) begin
            if (st.wraps == dpwpc_pkg::WRAPS_MAX) begin
               st.done  = 1'b1;
               st.width = dpwpc_pkg::WIDTH_SAT;
            end else begin
               st.wraps = st.wraps + 1'b1;
            end
         end
         if (st.armed) begin
            if (fall) begin
               st.width = dpwpc_pkg::WIDTH_BITS'(cnt_adv);
               st.done  = 1'b1;
            end
         end else if (rise) begin
            // restart the measurement from zero
            cnt_in     = '0;
            st.width   = '0;
            st.done    = 1'b0;
            st.armed   = 1'b1;
            st.wraps   = '0;
            armed_rise = 1'b1;
         end
      end
   end

   assign status_next = st;
   assign count_next  = cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff    <= '0;
         cnt_ff    <= '0;
         last_ff   <= 1'b0;
         status_ff <= '0;
      end else if (step) begin
         pre_ff    <= pre_in;
         cnt_ff    <= cnt_in;
         last_ff   <= level;
         status_ff <= st;
      end
   end

   a_clear_drops_done: assert property (@(posedge clock) disable iff (reset)
      step && clear |=> !status_ff.done)
      else $error("done survived a clear");

   a_rise_zeroes: assert property (@(posedge clock) disable iff (reset)
      step && armed_rise |=> cnt_ff == '0 && status_ff.width == '0 && status_ff.armed)
      else $error("rising edge did not restart the channel");

   a_wraps_need_arm: assert property (@(posedge clock) disable iff (reset)
      status_ff.wraps != '0 |-> status_ff.armed)
      else $error("wraps counted while not armed");

   a_done_needs_arm: assert property (@(posedge clock) disable iff (reset)
      status_ff.done |-> status_ff.armed)
      else $error("done set while not armed");

endmodule

// ===== sv/dual_pulse_width_phase_capture_top.sv =====
// ----------------------------------------------------------------------------
// dual_pulse_width_phase_capture_top
// Two-channel high-time capture with phase of B against A.
// ----------------------------------------------------------------------------
// Each request word is one sample tick carrying the levels of A and B and
// their clear bits; each produces exactly one response word with both
// channels' status, widths and the phase count. The block takes one word
// every cycle unless the response side stalls: a word sits in the input
// register while both channel updates resolve in a single pass, then lands
// in the response register, which holds the response until the response
// side is ready to take it. A stalled response holds the pipeline; the
// input register still takes one more word while the result waits.
// Register writes (index 0 reload limit, index 1 prescale) are taken every
// cycle and are meant to happen only while no word is in flight.
module dual_pulse_width_phase_capture_top (
   input  logic              clock,
   input  logic              reset,
   dpwpc_req_if.sink         req_ch,
   dpwpc_rsp_if.source       rsp_ch,
   dpwpc_csr_if.sink         csr_ch
);

   dpwpc_pkg::cfg_type cfg_ff, cfg_in;

   logic in_valid_ff, in_valid_in;
   logic level_a_ff, level_b_ff, clear_a_ff, clear_b_ff;
   logic out_valid_ff, out_valid_in;
   logic step, req_take;

   dpwpc_pkg::chan_status_type status_a, status_b;
   dpwpc_pkg::chan_status_type rsp_a_ff, rsp_b_ff;
   dpwpc_pkg::count_type       count_a, count_b;
   logic                       rise_a, rise_b;
   logic [dpwpc_pkg::WIDTH_BITS-1:0] phase_ff, phase_in;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (dpwpc_pkg::csr_index_type'(csr_ch.index))
            dpwpc_pkg::REG_RELOAD_LIMIT: cfg_in.reload_limit = csr_ch.data;
            dpwpc_pkg::REG_PRESCALE:
               cfg_in.prescale = csr_ch.data[dpwpc_pkg::PRESCALE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reload_limit <= dpwpc_pkg::RELOAD_RESET;
         cfg_ff.prescale     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_a_ff <= req_ch.level_a;
         level_b_ff <= req_ch.level_b;
         clear_a_ff <= req_ch.clear_a;
         clear_b_ff <= req_ch.clear_b;
      end
      if (step) begin
         rsp_a_ff <= status_a;
         rsp_b_ff <= status_b;
      end
   end

   dpwpc_channel u_chan_a (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .level       (level_a_ff),
      .clear       (clear_a_ff),
      .cfg         (cfg_ff),
      .status_next (status_a),
      .count_next  (count_a),
      .armed_rise  (rise_a)
   );

   dpwpc_channel u_chan_b (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .level       (level_b_ff),
      .clear       (clear_b_ff),
      .cfg         (cfg_ff),
      .status_next (status_b),
      .count_next  (count_b),
      .armed_rise  (rise_b)
   );

   // B's rising edge samples A's count after A's own edge handling
   assign phase_in = rise_b ? dpwpc_pkg::WIDTH_BITS'(count_a) : phase_ff;

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.done_a      = rsp_a_ff.done;
   assign rsp_ch.armed_a     = rsp_a_ff.armed;
   assign rsp_ch.wraps_a     = rsp_a_ff.wraps;
   assign rsp_ch.width_a     = rsp_a_ff.width;
   assign rsp_ch.done_b      = rsp_b_ff.done;
   assign rsp_ch.armed_b     = rsp_b_ff.armed;
   assign rsp_ch.wraps_b     = rsp_b_ff.wraps;
   assign rsp_ch.width_b     = rsp_b_ff.width;
   assign rsp_ch.phase_count = phase_ff;

   // count_b feeds only the channel's own state
   logic unused_count_b;
   assign unused_count_b = ^count_b ^ rise_a;

endmodule

// ===== bench/capture_checker.sv =====
// ----------------------------------------------------------------------------
// capture_checker
// Watches the request, response and register channels of the capture block,
// runs its own cycle model of both channels for every accepted request word
// and compares each response word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module capture_checker (
   input  logic  clock,
   input  logic  reset,
   dpwpc_req_if  req,
   dpwpc_rsp_if  rsp,
   dpwpc_csr_if  csr,
   output int    mismatch_count,
   output int    words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [dpwpc_pkg::PRESCALE_BITS-1:0] tick;
      dpwpc_pkg::count_type                count;
      logic                                level;
      dpwpc_pkg::chan_status_type          st;
   } channel_state_type;

   typedef struct {
      dpwpc_pkg::chan_status_type       a;
      dpwpc_pkg::chan_status_type       b;
      logic [dpwpc_pkg::WIDTH_BITS-1:0] phase;
   } capture_result_type;

   channel_state_type                   chan_a;
   channel_state_type                   chan_b;
   logic [dpwpc_pkg::WIDTH_BITS-1:0]    phase_hold;
   logic [dpwpc_pkg::CSR_DATA_BITS-1:0] reload_limit;
   logic [dpwpc_pkg::PRESCALE_BITS-1:0] prescale;
   capture_result_type                  expected_results[$];
   int                                  mismatches = 0;

   // Step the prescaler and counter by one tick; high when the counter wraps.
   function automatic logic advance_timer(inout channel_state_type ch);
      if (ch.tick >= prescale) begin
         ch.tick = '0;
         if (ch.count >= dpwpc_pkg::count_type'(reload_limit)) begin
            ch.count = '0;
            return 1'b1;
         end
         ch.count = ch.count + 1'b1;
      end else begin
         ch.tick = ch.tick + 1'b1;
      end
      return 1'b0;
   endfunction

   // Clear, then wrap, then edge; high on a rising edge that arms the channel.
   function automatic logic update_channel(inout channel_state_type ch, input logic level,
                                           input logic clear, input logic wrapped);
      logic rise;
      logic fall;
      rise = level && !ch.level;
      fall = !level && ch.level;
      ch.level = level;
      if (clear) begin
         ch.st.done  = 1'b0;
         ch.st.armed = 1'b0;
         ch.st.wraps = '0;
      end
      if (ch.st.done)
         return 1'b0;
      if (wrapped && ch.st.armed) begin
         if (ch.st.wraps == dpwpc_pkg::WRAPS_MAX) begin
            ch.st.done  = 1'b1;
            ch.st.width = dpwpc_pkg::WIDTH_SAT;
         end else begin
            ch.st.wraps = ch.st.wraps + 1'b1;
         end
      end
      // a saturated channel still latches the count on the same falling edge
      if (ch.st.armed) begin
         if (fall) begin
            ch.st.width = ch.count;
            ch.st.done  = 1'b1;
         end
      end else if (rise) begin
         ch.count    = '0;
         ch.st.width = '0;
         ch.st.done  = 1'b0;
         ch.st.armed = 1'b1;
         ch.st.wraps = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic capture_result_type predict_tick(logic la, logic lb, logic ca,
                                                       logic cb);
      logic               wrap_a;
      logic               wrap_b;
      capture_result_type res;
      wrap_a = advance_timer(chan_a);
      wrap_b = advance_timer(chan_b);
      void'(update_channel(chan_a, la, ca, wrap_a));
      // A is already handled, so a simultaneous rise latches zero
      if (update_channel(chan_b, lb, cb, wrap_b))
         phase_hold = chan_a.count;
      res.a     = chan_a.st;
      res.b     = chan_b.st;
      res.phase = phase_hold;
      return res;
   endfunction

   function automatic void check_field(string field,
                                       logic [dpwpc_pkg::WIDTH_BITS-1:0] want,
                                       logic [dpwpc_pkg::WIDTH_BITS-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      capture_result_type want;
      if (reset) begin
         chan_a       = '{default: '0};
         chan_b       = '{default: '0};
         phase_hold   = '0;
         reload_limit = dpwpc_pkg::RELOAD_RESET;
         prescale     = '0;
         expected_results.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               dpwpc_pkg::REG_RELOAD_LIMIT: reload_limit = csr.data;
               dpwpc_pkg::REG_PRESCALE:
                  prescale = csr.data[dpwpc_pkg::PRESCALE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: response word arrived with no prediction pending", $time);
            end else begin
               want = expected_results.pop_front();
               check_field("done_a", want.a.done, rsp.done_a);
               check_field("armed_a", want.a.armed, rsp.armed_a);
               check_field("wraps_a", want.a.wraps, rsp.wraps_a);
               check_field("width_a", want.a.width, rsp.width_a);
               check_field("done_b", want.b.done, rsp.done_b);
               check_field("armed_b", want.b.armed, rsp.armed_b);
               check_field("wraps_b", want.b.wraps, rsp.wraps_b);
               check_field("width_b", want.b.width, rsp.width_b);
               check_field("phase_count", want.phase, rsp.phase_count);
            end
         end
         if (req.valid && req.ready)
            expected_results.push_back(predict_tick(req.level_a, req.level_b,
                                                    req.clear_a, req.clear_b));
      end
      mismatch_count  <= mismatches;
      words_in_flight <= expected_results.size();
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives sample ticks into the dual pulse-width and phase capture block: a
// short directed sequence of edges and clears, then random pulse trains under
// several reload and prescale settings, with bursty requests and a stalling
// response side. The checker beside the block does the prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 6;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DIRECTED_COUNT  = 19;

   // {level_a, level_b, clear_a, clear_b}, first tick in the top nibble
   localparam logic [4*DIRECTED_COUNT-1:0] DIRECTED_TICKS = {
      4'b0000, 4'b1000, 4'b1000, 4'b1100, 4'b1100, 4'b0100, 4'b0000,
      4'b1000, 4'b0000, 4'b0011, 4'b1100, 4'b1111, 4'b0000, 4'b1100,
      4'b1000, 4'b1101, 4'b1110, 4'b0000, 4'b0011
   };

   logic clock;
   logic reset;
   int   mismatch_count;
   int   in_flight;
   int   idle_cycles = 0;
   int   hold_off_req = 0;
   int   burst_left = 0;
   logic lvl_a = 1'b0;
   logic lvl_b = 1'b0;
   int   run_a = 0;
   int   run_b = 0;

   dpwpc_req_if req_ch ();
   dpwpc_rsp_if rsp_ch ();
   dpwpc_csr_if csr_ch ();

   dual_pulse_width_phase_capture_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   capture_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr             (csr_ch),
      .mismatch_count  (mismatch_count),
      .words_in_flight (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one word, opening a new burst after a random gap when needed.
   task automatic send_word(input logic la, input logic lb, input logic ca, input logic cb);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.level_a <= la;
      req_ch.level_b <= lb;
      req_ch.clear_a <= ca;
      req_ch.clear_b <= cb;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold the sender until every predicted word has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [dpwpc_pkg::CSR_DATA_BITS-1:0] reload,
                            input logic [dpwpc_pkg::PRESCALE_BITS-1:0] pre);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= dpwpc_pkg::REG_RELOAD_LIMIT;
      csr_ch.data  <= reload;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= dpwpc_pkg::REG_PRESCALE;
      csr_ch.data  <= dpwpc_pkg::CSR_DATA_BITS'(pre);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Advance one line's pulse train: toggle when the run ends, clear mostly
   // while the line rests low so the next rise arms again.
   function automatic void pulse_line(inout logic lvl, inout int run, input int long_pct,
                                      output logic clr);
      logic was;
      was = lvl;
      if (run == 0) begin
         lvl = !lvl;
         if (lvl && $urandom_range(0, 99) < long_pct)
            run = $urandom_range(64, 140);
         else
            run = $urandom_range(1, 10);
      end
      run--;
      clr = (!lvl && !was && $urandom_range(0, 2) == 0) ||
            (run < 12 && $urandom_range(0, 49) == 0);
   endfunction

   task automatic run_pulses(input int words, input int long_pct);
      logic ca;
      logic cb;
      repeat (words) begin
         pulse_line(lvl_a, run_a, long_pct, ca);
         pulse_line(lvl_b, run_b, long_pct, cb);
         send_word(lvl_a, lvl_b, ca, cb);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.level_a <= 1'b0;
      req_ch.level_b <= 1'b0;
      req_ch.clear_a <= 1'b0;
      req_ch.clear_b <= 1'b0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= dpwpc_pkg::REG_RELOAD_LIMIT;
      csr_ch.data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_word(DIRECTED_TICKS[4*(DIRECTED_COUNT-1-i)+3],
                   DIRECTED_TICKS[4*(DIRECTED_COUNT-1-i)+2],
                   DIRECTED_TICKS[4*(DIRECTED_COUNT-1-i)+1],
                   DIRECTED_TICKS[4*(DIRECTED_COUNT-1-i)]);
      end

      // zero reload wraps every count: a long high pulse saturates both channels
      configure('0, '0);
      lvl_a = 1'b1;
      run_a = 70;
      lvl_b = 1'b1;
      run_b = 75;
      run_pulses(110, 0);

      configure(32'd1, '0);
      run_pulses(80, 25);

      configure(32'd3, 16'd2);
      run_pulses(60, 10);

      configure('1, '1);
      run_pulses(40, 0);

      configure($urandom, 16'($urandom_range(0, 65535)));
      run_pulses(40, 0);

      configure(32'($urandom_range(2, 9)), 16'($urandom_range(0, 3)));
      hold_off_req <= hold_off_req + 1;
      run_pulses(100, 10);

      drain();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Response side: the stall pattern steps through four modes in turn; on
   // request, hold off long enough for the block to back up into its input.
   initial begin
      int cyc;
      int seen;
      cyc  = 0;
      seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_off_req != seen) begin
            seen = hold_off_req;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            case ((cyc / 48) % 4)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= (cyc % 3) != 0;
               2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
sv/dpwpc_pkg.sv
sv/dpwpc_if.sv
sv/dpwpc_channel.sv
sv/dual_pulse_width_phase_capture_top.sv
bench/capture_checker.sv
bench/testbench.sv
